>>> rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> rtl/bnc_pkg.sv
package bnc_pkg;

  localparam logic [6:0] BASS_LOW      = 7'd36;
  localparam logic [6:0] ALT_LIMIT     = 7'd24;
  localparam logic [6:0] STEP_LIMIT    = 7'd5;
  localparam logic [4:0] DEFAULT_FIFTH = 5'd7;

  localparam logic [1:0] PROF_ROOT   = 2'd0;
  localparam logic [1:0] PROF_FLOW   = 2'd1;
  localparam logic [1:0] PROF_BOUNCE = 2'd2;
  localparam logic [1:0] PROF_PEDAL  = 2'd3;

  localparam logic REG_FLOW   = 1'b0;
  localparam logic REG_BOUNCE = 1'b1;

  localparam logic [8:0] FLOW_RESET   = 9'd85;
  localparam logic [8:0] BOUNCE_RESET = 9'd169;

  typedef logic [3:0] pc_t;
  typedef logic [6:0] note_t;

  typedef struct packed {
    logic [8:0] flow_thr;
    logic [8:0] bounce_thr;
  } cfg_t;

  typedef struct packed {
    logic [3:0] chord_root;
    logic [2:0] tone_count;
    logic [4:0] first_offset;
    logic [4:0] third_offset;
    logic [4:0] fifth_offset;
    logic [7:0] motion_level;
    logic [2:0] profile_override;
    logic [3:0] tonal_center;
    logic [7:0] slot_index;
    logic       has_previous;
    logic [6:0] previous_bass;
  } item_t;

  typedef struct packed {
    logic [5:0] bass_pitch;
    logic [1:0] profile_used;
  } result_t;

  // Sums reach at most 46 (root 15 plus offset 31), so three folds suffice.
  function automatic pc_t fold12(input logic [5:0] s);
    logic [5:0] r;
    if (s >= 6'd36) begin
      r = s - 6'd36;
    end else if (s >= 6'd24) begin
      r = s - 6'd24;
    end else if (s >= 6'd12) begin
      r = s - 6'd12;
    end else begin
      r = s;
    end
    return r[3:0];
  endfunction

  function automatic note_t place_low(input logic [5:0] s);
    return BASS_LOW + {3'b000, fold12(s)};
  endfunction

  function automatic note_t dist_of(input note_t a, input note_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> rtl/bnc_pick.sv
module bnc_pick (
  input  bnc_pkg::item_t   item,
  input  bnc_pkg::cfg_t    cfg,
  output bnc_pkg::result_t result
);
  import bnc_pkg::*;

  logic [1:0] profile;
  logic       use0, use1, use2;
  logic [5:0] root6;
  note_t      p0r, p0, p1, p2;
  note_t      d0r, d0, d1, d2;
  note_t      best, bestd;
  note_t      alt, altd;
  logic       found;
  logic       repeat_hit;
  pc_t        root_pc;
  pc_t        best_pc;
  logic [4:0] fifth;
  note_t      bounce_note;
  note_t      flow_note;
  note_t      pitch;

  assign root6 = {2'b00, item.chord_root};
  assign use0  = (item.tone_count >= 3'd1);
  assign use1  = (item.tone_count >= 3'd2);
  assign use2  = (item.tone_count >= 3'd3);

  always_comb begin
    if (!item.profile_override[2]) begin
      profile = item.profile_override[1:0];
    end else if ({1'b0, item.motion_level} < cfg.flow_thr) begin
      profile = PROF_ROOT;
    end else if ({1'b0, item.motion_level} < cfg.bounce_thr) begin
      profile = PROF_FLOW;
    end else begin
      profile = PROF_BOUNCE;
    end
  end

  assign p0r = place_low(root6);
  assign p0  = place_low(root6 + {1'b0, item.first_offset});
  assign p1  = place_low(root6 + {1'b0, item.third_offset});
  assign p2  = place_low(root6 + {1'b0, item.fifth_offset});
  assign d0r = dist_of(p0r, item.previous_bass);
  assign d0  = dist_of(p0, item.previous_bass);
  assign d1  = dist_of(p1, item.previous_bass);
  assign d2  = dist_of(p2, item.previous_bass);

  // nearest tone, earlier one wins ties
  always_comb begin
    best  = p0r;
    bestd = d0r;
    if (use1 && (d1 < bestd)) begin
      best  = p1;
      bestd = d1;
    end
    if (use2 && (d2 < bestd)) begin
      best  = p2;
      bestd = d2;
    end
  end

  // nearest tone other than the previous note, closer than ALT_LIMIT
  always_comb begin
    alt   = '0;
    altd  = ALT_LIMIT;
    found = 1'b0;
    if (use0 && (p0 != item.previous_bass) && (d0 < altd)) begin
      alt   = p0;
      altd  = d0;
      found = 1'b1;
    end
    if (use1 && (p1 != item.previous_bass) && (d1 < altd)) begin
      alt   = p1;
      altd  = d1;
      found = 1'b1;
    end
    if (use2 && (p2 != item.previous_bass) && (d2 < altd)) begin
      alt   = p2;
      altd  = d2;
      found = 1'b1;
    end
  end

  // best sits in 36..47, so its pitch class is best - 36
  assign root_pc    = fold12(root6);
  assign best_pc    = 4'(best - BASS_LOW);
  assign repeat_hit = (best == item.previous_bass) && (best_pc != root_pc);

  always_comb begin
    if (!item.has_previous) begin
      flow_note = p0r;
    end else if (repeat_hit && found && (altd <= STEP_LIMIT)) begin
      flow_note = alt;
    end else begin
      flow_note = best;
    end
  end

  assign fifth       = use2 ? item.fifth_offset : DEFAULT_FIFTH;
  assign bounce_note = place_low(root6 + (item.slot_index[0] ? {1'b0, fifth} : 6'd0));

  always_comb begin
    unique case (profile)
      PROF_ROOT:   pitch = p0r;
      PROF_FLOW:   pitch = flow_note;
      PROF_BOUNCE: pitch = bounce_note;
      PROF_PEDAL:  pitch = place_low({2'b00, item.tonal_center});
      default:     pitch = p0r;
    endcase
  end

  assign result.bass_pitch   = pitch[5:0];
  assign result.profile_used = profile;

endmodule

>>> rtl/bass_note_chooser.sv
// Bass note chooser: one chord request in, one bass pitch (36..47) and the profile
// used out, one request per clock unless stalled. The path: an input register,
// the pick logic, then the result register. While a result waits on m_tready the
// input register takes one more request and then s_tready drops, so throughput
// is one request per cycle whenever the output side takes results. Thresholds
// sit at byte address 0 (flow) and 4 (bounce), 9 bits each; write them only
// while the block is idle.
module bass_note_chooser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // chord_root, tone_count, first_offset, third_offset, fifth_offset,
  // motion_level, tonal_center, slot_index, previous_bass, zero pad
  input  logic [55:0] s_tdata,
  // profile_override, has_previous
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // bass_pitch, zero pad
  output logic [7:0]  m_tdata,
  // profile_used
  output logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bnc_pkg::*;

  cfg_t    cfg;
  item_t   item_in;
  item_t   item_q;
  logic    in_valid;
  result_t res;
  result_t res_q;
  logic    out_valid;
  logic    advance;
  logic    cfg_wr;

  assign item_in.chord_root       = s_tdata[3:0];
  assign item_in.tone_count       = s_tdata[6:4];
  assign item_in.first_offset     = s_tdata[11:7];
  assign item_in.third_offset     = s_tdata[16:12];
  assign item_in.fifth_offset     = s_tdata[21:17];
  assign item_in.motion_level     = s_tdata[29:22];
  assign item_in.tonal_center     = s_tdata[33:30];
  assign item_in.slot_index       = s_tdata[41:34];
  assign item_in.previous_bass    = s_tdata[48:42];
  assign item_in.profile_override = s_tuser[2:0];
  assign item_in.has_previous     = s_tuser[3];

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item_q <= item_in;
    end
    if (advance && in_valid) begin
      res_q <= res;
    end
  end

  bnc_pick u_pick (
    .item   (item_q),
    .cfg    (cfg),
    .result (res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, res_q.bass_pitch};
  assign m_tuser  = res_q.profile_used;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flow_thr   <= FLOW_RESET;
      cfg.bounce_thr <= BOUNCE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FLOW:   cfg.flow_thr   <= pwdata[8:0];
        REG_BOUNCE: cfg.bounce_thr <= pwdata[8:0];
        default:    cfg.flow_thr   <= cfg.flow_thr;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FLOW:   prdata = {23'd0, cfg.flow_thr};
      REG_BOUNCE: prdata = {23'd0, cfg.bounce_thr};
      default:    prdata = '0;
    endcase
  end

endmodule

>>> rtl/bnc_checker.sv
`include "assert_macros.svh"

module bnc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser
);

  // result pitch always inside the bass window, pad bits clear
  `ASSERT_CLK(a_pitch_window, clk, rst, m_tvalid |-> (m_tdata >= 8'd36 && m_tdata <= 8'd47))

  // input side only stalls when a result is pending
  `ASSERT_CLK(a_stall_needs_result, clk, rst, !s_tready |-> m_tvalid)

  // a held result keeps its value
  `ASSERT_CLK(a_hold, clk, rst,
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))

  // nothing is offered right after reset
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid)

endmodule

bind bass_note_chooser bnc_checker u_bnc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
